>>> design/rhbp_pkg.sv
// Shared types, codes and tables for the HTTP request byte parser.
`default_nettype none
package rhbp_pkg;

    localparam int MAX_METHOD_LETTERS = 7;
    localparam int METHOD_LEN_W       = $clog2(MAX_METHOD_LETTERS + 2);
    localparam int METHOD_COUNT       = 9;
    localparam int TABLE_CHARS        = 8;
    localparam int KEY_LEN            = 14;
    localparam int KEY_POS_W          = $clog2(KEY_LEN + 1);

    localparam logic [30:0] INT_TOP = 31'h7FFF_FFFF;

    // byte classes
    localparam logic [3:0] CLS_METHOD     = 4'd0;
    localparam logic [3:0] CLS_METHOD_END = 4'd1;
    localparam logic [3:0] CLS_URI        = 4'd2;
    localparam logic [3:0] CLS_URI_END    = 4'd3;
    localparam logic [3:0] CLS_VERSION    = 4'd4;
    localparam logic [3:0] CLS_LINE_END   = 4'd5;
    localparam logic [3:0] CLS_KEY        = 4'd6;
    localparam logic [3:0] CLS_COLON      = 4'd7;
    localparam logic [3:0] CLS_VALUE      = 4'd8;
    localparam logic [3:0] CLS_HDR_END    = 4'd9;
    localparam logic [3:0] CLS_BODY       = 4'd10;
    localparam logic [3:0] CLS_IGNORED    = 4'd11;

    // error causes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_METHOD     = 2'd1;
    localparam logic [1:0] ERR_LINE_END   = 2'd2;
    localparam logic [1:0] ERR_LENGTH     = 2'd3;

    // method code before a name has matched
    localparam logic [3:0] METHOD_NONE    = 4'd0;

    // scan phases of a Content-Length value
    localparam logic [1:0] SCAN_BLANKS    = 2'd0;
    localparam logic [1:0] SCAN_SIGN      = 2'd1;
    localparam logic [1:0] SCAN_DIGITS    = 2'd2;
    localparam logic [1:0] SCAN_STOPPED   = 2'd3;

    // special characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0] METHOD_TABLE [METHOD_COUNT][TABLE_CHARS] = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00}
    };

    localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7
    };

    localparam logic [7:0] LENGTH_KEY [KEY_LEN] = '{
        "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
    };

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [3:0]  method_code;
        logic        request_done;
        logic        parse_error;
        logic [1:0]  error_cause;
        logic [30:0] body_remaining;
    } rhbp_result_t;

    // letter i of method m, zero beyond the stored table width
    function automatic logic [7:0] method_char(input int m, input int i);
        logic [7:0] ch;
        ch = 8'h00;
        if (i < TABLE_CHARS)
        begin
            ch = METHOD_TABLE[m[3:0]][i[2:0]];
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> design/rhbp_byte_if.sv
// Valid/ready channel carrying one request byte per transaction.
`default_nettype none
interface rhbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

>>> design/rhbp_result_if.sv
// Valid/ready channel carrying one parse result per transaction.
`default_nettype none
interface rhbp_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  byte_class;
    logic [3:0]  method_code;
    logic        request_done;
    logic        parse_error;
    logic [1:0]  error_cause;
    logic [30:0] body_remaining;

    modport source (output valid, output byte_class, output method_code,
                    output request_done, output parse_error, output error_cause,
                    output body_remaining, input ready);
    modport sink   (input valid, input byte_class, input method_code,
                    input request_done, input parse_error, input error_cause,
                    input body_remaining, output ready);
endinterface
`default_nettype wire

>>> design/rhbp_method_lookup.sv
// Matches the collected method letters against the standard method table.
`default_nettype none
module rhbp_method_lookup
    import rhbp_pkg::*;
(
    input  wire logic [MAX_METHOD_LETTERS-1:0][7:0] letters,
    input  wire logic [METHOD_LEN_W-1:0]            length,
    output logic      [3:0]                         code
);

    always_comb
    begin
        logic same;
        code = METHOD_NONE;
        // walk backwards so the first table entry wins
        for (int m = METHOD_COUNT - 1; m >= 0; m--)
        begin
            same = (int'(length) == int'(METHOD_LEN[m]))
                && (int'(METHOD_LEN[m]) <= MAX_METHOD_LETTERS);
            for (int i = 0; i < MAX_METHOD_LETTERS; i++)
            begin
                if ((i < int'(METHOD_LEN[m])) && (letters[i] != method_char(m, i)))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                code = 4'(m + 1);
            end
        end
    end

endmodule
`default_nettype wire

>>> design/rhbp_value_scan.sv
// Decimal scanner for the Content-Length value: blanks, sign, digits.
`default_nettype none
module rhbp_value_scan
    import rhbp_pkg::*;
(
    input  wire logic [7:0]  c,
    input  wire logic [1:0]  scan_phase,
    input  wire logic        negative,
    input  wire logic        bad,
    input  wire logic [30:0] acc,
    output logic      [1:0]  scan_phase_next,
    output logic             negative_next,
    output logic             bad_next,
    output logic      [30:0] acc_next
);

    logic        digit;
    logic        blank;
    logic        take_digit;
    logic [34:0] sum;

    assign digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign sum   = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, c[3:0]};

    always_comb
    begin
        scan_phase_next = scan_phase;
        negative_next   = negative;
        bad_next        = bad;
        acc_next        = acc;
        take_digit      = 1'b0;
        case (scan_phase)
            SCAN_BLANKS:
            begin
                if (blank)
                begin
                    take_digit = 1'b0;
                end
                else if ((c == CHAR_PLUS) || (c == CHAR_MINUS))
                begin
                    negative_next   = (c == CHAR_MINUS);
                    scan_phase_next = SCAN_SIGN;
                end
                else
                begin
                    scan_phase_next = digit ? SCAN_DIGITS : SCAN_STOPPED;
                    take_digit      = digit;
                end
            end
            SCAN_SIGN:
            begin
                scan_phase_next = digit ? SCAN_DIGITS : SCAN_STOPPED;
                take_digit      = digit;
            end
            SCAN_DIGITS:
            begin
                if (digit)
                begin
                    take_digit = 1'b1;
                end
                else
                begin
                    scan_phase_next = SCAN_STOPPED;
                end
            end
            default:
            begin
                take_digit = 1'b0;
            end
        endcase

        if (take_digit)
        begin
            // clamp on overflow and mark the value bad
            if (sum > {4'd0, INT_TOP})
            begin
                bad_next = 1'b1;
                acc_next = INT_TOP;
            end
            else
            begin
                acc_next = sum[30:0];
            end
            if (negative_next && (acc_next != 31'd0))
            begin
                bad_next = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/rhbp_parser.sv
// Request phase tracker: holds per-request state and computes each byte's result.
`default_nettype none
module rhbp_parser
    import rhbp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    output rhbp_result_t      result
);

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_METHOD  = 4'd1;
    localparam logic [3:0] PH_URI     = 4'd2;
    localparam logic [3:0] PH_VERSION = 4'd3;
    localparam logic [3:0] PH_CRLF    = 4'd4;
    localparam logic [3:0] PH_KEY     = 4'd5;
    localparam logic [3:0] PH_VALUE   = 4'd6;
    localparam logic [3:0] PH_EMPTY   = 4'd7;
    localparam logic [3:0] PH_BODY    = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;
    localparam logic [3:0] PH_ERROR   = 4'd10;

    logic [3:0]                         phase_reg, phase_next, cur_phase;
    logic [MAX_METHOD_LETTERS-1:0][7:0] letters_reg, letters_next, cur_letters;
    logic [METHOD_LEN_W-1:0]            mlen_reg, mlen_next, cur_mlen;
    logic [3:0]                         method_id_reg, method_id_next, cur_method_id;
    logic [KEY_POS_W-1:0]               kpos_reg, kpos_next, cur_kpos;
    logic                               mismatch_reg, mismatch_next, cur_mismatch;
    logic [30:0]                        acc_reg, acc_next, cur_acc;
    logic [1:0]                         scan_reg, scan_next, cur_scan;
    logic                               neg_reg, neg_next, cur_neg;
    logic                               bad_reg, bad_next, cur_bad;
    logic                               seen_reg, seen_next, cur_seen;
    logic [30:0]                        latched_reg, latched_next, cur_latched;
    logic                               invalid_reg, invalid_next, cur_invalid;
    logic [30:0]                        remaining_reg, remaining_next, cur_remaining;
    logic [1:0]                         reason_reg, reason_next;

    logic        start;
    logic [3:0]  lookup_code;
    logic [1:0]  sc_phase;
    logic        sc_neg;
    logic        sc_bad;
    logic [30:0] sc_acc;
    logic [3:0]  cls;
    logic        done;

    // a new request starts from cleared state
    assign start         = (phase_reg == PH_START) || (phase_reg == PH_DONE);
    assign cur_phase     = start ? PH_METHOD : phase_reg;
    assign cur_letters   = start ? '0 : letters_reg;
    assign cur_mlen      = start ? '0 : mlen_reg;
    assign cur_method_id = start ? METHOD_NONE : method_id_reg;
    assign cur_kpos      = start ? '0 : kpos_reg;
    assign cur_mismatch  = start ? 1'b0 : mismatch_reg;
    assign cur_acc       = start ? 31'd0 : acc_reg;
    assign cur_scan      = start ? SCAN_BLANKS : scan_reg;
    assign cur_neg       = start ? 1'b0 : neg_reg;
    assign cur_bad       = start ? 1'b0 : bad_reg;
    assign cur_seen      = start ? 1'b0 : seen_reg;
    assign cur_latched   = start ? 31'd0 : latched_reg;
    assign cur_invalid   = start ? 1'b0 : invalid_reg;
    assign cur_remaining = start ? 31'd0 : remaining_reg;

    rhbp_method_lookup u_lookup (
        .letters (cur_letters),
        .length  (cur_mlen),
        .code    (lookup_code)
    );

    rhbp_value_scan u_scan (
        .c               (data_byte),
        .scan_phase      (cur_scan),
        .negative        (cur_neg),
        .bad             (cur_bad),
        .acc             (cur_acc),
        .scan_phase_next (sc_phase),
        .negative_next   (sc_neg),
        .bad_next        (sc_bad),
        .acc_next        (sc_acc)
    );

    always_comb
    begin
        phase_next     = cur_phase;
        letters_next   = cur_letters;
        mlen_next      = cur_mlen;
        method_id_next = cur_method_id;
        kpos_next      = cur_kpos;
        mismatch_next  = cur_mismatch;
        acc_next       = cur_acc;
        scan_next      = cur_scan;
        neg_next       = cur_neg;
        bad_next       = cur_bad;
        seen_next      = cur_seen;
        latched_next   = cur_latched;
        invalid_next   = cur_invalid;
        remaining_next = cur_remaining;
        reason_next    = reason_reg;
        cls            = CLS_IGNORED;
        done           = 1'b0;

        case (cur_phase)
            PH_METHOD:
            begin
                if (data_byte == CHAR_SPACE)
                begin
                    method_id_next = lookup_code;
                    if (lookup_code == METHOD_NONE)
                    begin
                        phase_next  = PH_ERROR;
                        reason_next = ERR_METHOD;
                    end
                    else
                    begin
                        cls        = CLS_METHOD_END;
                        phase_next = PH_URI;
                    end
                end
                else
                begin
                    cls = CLS_METHOD;
                    for (int i = 0; i < MAX_METHOD_LETTERS; i++)
                    begin
                        if (int'(cur_mlen) == i)
                        begin
                            letters_next[i] = data_byte;
                        end
                    end
                    // saturate one past the limit so a long name never matches
                    if (cur_mlen <= METHOD_LEN_W'(MAX_METHOD_LETTERS))
                    begin
                        mlen_next = cur_mlen + 1'b1;
                    end
                end
            end
            PH_URI:
            begin
                if (data_byte == CHAR_SPACE)
                begin
                    cls        = CLS_URI_END;
                    phase_next = PH_VERSION;
                end
                else
                begin
                    cls = CLS_URI;
                end
            end
            PH_VERSION:
            begin
                if (data_byte == CHAR_CR)
                begin
                    cls        = CLS_LINE_END;
                    phase_next = PH_CRLF;
                end
                else
                begin
                    cls = CLS_VERSION;
                end
            end
            PH_CRLF:
            begin
                if (data_byte == CHAR_LF)
                begin
                    cls        = CLS_LINE_END;
                    phase_next = PH_KEY;
                end
                else
                begin
                    phase_next  = PH_ERROR;
                    reason_next = ERR_LINE_END;
                end
            end
            PH_KEY:
            begin
                if (data_byte == CHAR_CR)
                begin
                    if (cur_seen && cur_invalid)
                    begin
                        phase_next  = PH_ERROR;
                        reason_next = ERR_LENGTH;
                    end
                    else
                    begin
                        if (cur_seen)
                        begin
                            remaining_next = cur_latched;
                        end
                        cls        = CLS_HDR_END;
                        phase_next = PH_EMPTY;
                    end
                end
                else if (data_byte == CHAR_COLON)
                begin
                    cls        = CLS_COLON;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    cls = CLS_KEY;
                    if ((int'(cur_kpos) < KEY_LEN)
                        && (data_byte == LENGTH_KEY[cur_kpos[KEY_POS_W-1:0]]))
                    begin
                        kpos_next = cur_kpos + 1'b1;
                    end
                    else
                    begin
                        mismatch_next = 1'b1;
                    end
                end
            end
            PH_VALUE:
            begin
                if (data_byte == CHAR_CR)
                begin
                    cls = CLS_LINE_END;
                    if (!cur_mismatch && (int'(cur_kpos) == KEY_LEN))
                    begin
                        seen_next    = 1'b1;
                        latched_next = cur_acc;
                        invalid_next = cur_bad || (cur_scan < SCAN_DIGITS);
                    end
                    kpos_next     = '0;
                    mismatch_next = 1'b0;
                    acc_next      = 31'd0;
                    scan_next     = SCAN_BLANKS;
                    neg_next      = 1'b0;
                    bad_next      = 1'b0;
                    phase_next    = PH_CRLF;
                end
                else
                begin
                    cls       = CLS_VALUE;
                    scan_next = sc_phase;
                    neg_next  = sc_neg;
                    bad_next  = sc_bad;
                    acc_next  = sc_acc;
                end
            end
            PH_EMPTY:
            begin
                if (data_byte != CHAR_LF)
                begin
                    phase_next  = PH_ERROR;
                    reason_next = ERR_LINE_END;
                end
                else
                begin
                    cls = CLS_HDR_END;
                    if (cur_remaining == 31'd0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                cls = CLS_BODY;
                if (cur_remaining != 31'd0)
                begin
                    remaining_next = cur_remaining - 31'd1;
                end
                if (remaining_next == 31'd0)
                begin
                    done       = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase
    end

    always_comb
    begin
        result.byte_class     = cls;
        result.method_code    = method_id_next;
        result.request_done   = done;
        result.parse_error    = (phase_next == PH_ERROR);
        result.error_cause    = reason_next;
        result.body_remaining = remaining_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            letters_reg   <= '0;
            mlen_reg      <= '0;
            method_id_reg <= METHOD_NONE;
            kpos_reg      <= '0;
            mismatch_reg  <= 1'b0;
            acc_reg       <= 31'd0;
            scan_reg      <= SCAN_BLANKS;
            neg_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            latched_reg   <= 31'd0;
            invalid_reg   <= 1'b0;
            remaining_reg <= 31'd0;
            reason_reg    <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            letters_reg   <= letters_next;
            mlen_reg      <= mlen_next;
            method_id_reg <= method_id_next;
            kpos_reg      <= kpos_next;
            mismatch_reg  <= mismatch_next;
            acc_reg       <= acc_next;
            scan_reg      <= scan_next;
            neg_reg       <= neg_next;
            bad_reg       <= bad_next;
            seen_reg      <= seen_next;
            latched_reg   <= latched_next;
            invalid_reg   <= invalid_next;
            remaining_reg <= remaining_next;
            reason_reg    <= reason_next;
        end
    end

    // an error freezes the phase, cause and remaining count
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_ERROR)
        |=> (phase_reg == PH_ERROR) && $stable(reason_reg) && $stable(remaining_reg))
        else $error("error state left or changed");

    // a completed request parks in the done phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.request_done |=> (phase_reg == PH_DONE))
        else $error("request_done without done phase");

    // cause is set exactly when the parser sits in the error phase
    a_cause_matches: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((phase_reg == PH_ERROR) == (reason_reg != ERR_NONE)))
        else $error("error cause out of step with error phase");

endmodule
`default_nettype wire

>>> design/http_request_byte_parser_top.sv
// Top level of the HTTP request byte parser: channels and result register.
// Usage:
//   request : byte channel, one request byte per transaction (valid/ready).
//   result  : one result per accepted byte, carrying the byte class, the method
//             code, request_done, the sticky parse_error with its cause, and
//             the number of body bytes still expected.
// Timing:
//   Each byte is parsed in the cycle it is accepted; its result is registered
//   and shown on result in the next cycle. Throughput is one byte per cycle
//   while result is not held back, set by the single pass through the phase
//   logic and the Content-Length multiply-by-ten ahead of the result register.
// Reset:
//   rst_n clears the parser to the start of a request with no error and the
//   result register to empty. The first byte after reset starts a request.
// Stalls:
//   While result is held back, the registered result waits; request.ready
//   stays high as long as the waiting result is taken in the same cycle, so
//   a new byte still enters whenever the result register frees up.
//   After an error every result is tagged ignored until the next reset.
`default_nettype none
module http_request_byte_parser_top
    import rhbp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rhbp_byte_if.sink     request,
    rhbp_result_if.source result
);

    logic         accept;
    logic         out_valid_reg;
    rhbp_result_t out_data_reg;
    rhbp_result_t parsed;

    // accept when the result register is empty or being drained this cycle
    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    rhbp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (request.data_byte),
        .result    (parsed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            out_valid_reg <= request.valid;
        end
    end

    // payload needs no reset; load only with a new transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= parsed;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.byte_class     = out_data_reg.byte_class;
    assign result.method_code    = out_data_reg.method_code;
    assign result.request_done   = out_data_reg.request_done;
    assign result.parse_error    = out_data_reg.parse_error;
    assign result.error_cause    = out_data_reg.error_cause;
    assign result.body_remaining = out_data_reg.body_remaining;

    // input only backs off when a result is waiting and not taken
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !request.ready |-> (result.valid && !result.ready))
        else $error("request stalled without a waiting result");

    // once an error is reported, every later result reports it too
    a_error_reported_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.parse_error
        |=> !result.valid || result.parse_error)
        else $error("parse_error dropped before reset");

    // an errored result is ignored and never completes a request
    a_error_result_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        accept && parsed.parse_error
        |=> (out_data_reg.byte_class == CLS_IGNORED) && !out_data_reg.request_done)
        else $error("errored byte not tagged ignored");

endmodule
`default_nettype wire
